/* rtl/lbbf_pkg.sv */
package lbbf_pkg;

  // label set and code range of digit cells
  localparam int NUM_LABELS = 10;
  localparam int LABEL_W    = 4;
  localparam int COUNT_W    = 4;
  localparam int CODE_W     = 8;
  localparam int COORD_W    = 8;
  localparam int CFG_W      = 9;

  localparam logic [CODE_W-1:0] CODE_ZERO = 8'd48;
  localparam logic [CODE_W-1:0] CODE_NINE = 8'd57;

  // configuration register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic [CFG_W-1:0] COLUMNS_RESET = 9'd140;
  localparam logic [CFG_W-1:0] ROWS_RESET    = 9'd50;

  // depth of the internal queues (power of two)
  localparam int QUEUE_DEPTH = 4;

  // one result as it leaves the block
  typedef struct packed {
    logic               box_valid;
    logic [LABEL_W-1:0] label_digit;
    logic [COORD_W-1:0] left_column;
    logic [COORD_W-1:0] top_row;
    logic [COORD_W-1:0] right_column;
    logic [COORD_W-1:0] bottom_row;
    logic               last_box;
  } res_t;

endpackage

/* rtl/lbbf_fifo.sv */
module lbbf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // slot storage, payload only
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

/* rtl/lbbf_front.sv */
module lbbf_front #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic                                   cfg_index,
  input  logic [lbbf_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   push,
  input  logic [lbbf_pkg::CODE_W-1:0]            cell_code,
  output logic                                   full,
  output logic                                   q_push,
  output logic [1+1+lbbf_pkg::LABEL_W+$clog2(MAX_COLUMNS)+$clog2(MAX_ROWS)-1:0] q_data,
  input  logic                                   q_full
);

  localparam int XW  = $clog2(MAX_COLUMNS);
  localparam int YW  = $clog2(MAX_ROWS);
  localparam int XCW = (XW + 1 > lbbf_pkg::CFG_W) ? XW + 1 : lbbf_pkg::CFG_W;
  localparam int YCW = (YW + 1 > lbbf_pkg::CFG_W) ? YW + 1 : lbbf_pkg::CFG_W;

  logic [lbbf_pkg::CFG_W-1:0]   columns_in_use;
  logic [lbbf_pkg::CFG_W-1:0]   rows_in_use;
  logic [XW-1:0]                col_pos;
  logic [YW-1:0]                row_pos;
  logic [XCW-1:0]               cols_ext;
  logic [XCW-1:0]               cols_clamped;
  logic [YCW-1:0]               rows_ext;
  logic [YCW-1:0]               rows_clamped;
  logic [XW-1:0]                last_col;
  logic [YW-1:0]                last_row;
  logic                         row_end;
  logic                         frame_end;
  logic                         digit_ok;
  logic [lbbf_pkg::LABEL_W-1:0] digit;
  logic                         accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  // frame size clamped to 1..MAX, taken straight from the registers
  always_comb begin
    cols_ext = XCW'(columns_in_use);
    rows_ext = YCW'(rows_in_use);
    if (cols_ext == '0) begin
      cols_clamped = XCW'(1);
    end else if (cols_ext > XCW'(MAX_COLUMNS)) begin
      cols_clamped = XCW'(MAX_COLUMNS);
    end else begin
      cols_clamped = cols_ext;
    end
    if (rows_ext == '0) begin
      rows_clamped = YCW'(1);
    end else if (rows_ext > YCW'(MAX_ROWS)) begin
      rows_clamped = YCW'(MAX_ROWS);
    end else begin
      rows_clamped = rows_ext;
    end
    last_col = XW'(cols_clamped - XCW'(1));
    last_row = YW'(rows_clamped - YCW'(1));
  end

  assign row_end   = (col_pos >= last_col);
  assign frame_end = row_end && (row_pos >= last_row);

  // classify the cell
  assign digit_ok = (cell_code >= lbbf_pkg::CODE_ZERO) && (cell_code <= lbbf_pkg::CODE_NINE);
  assign digit    = lbbf_pkg::LABEL_W'(cell_code - lbbf_pkg::CODE_ZERO);

  // only label cells and the frame's last cell go to the back part
  assign q_push = accept && (digit_ok || frame_end);
  assign q_data = {frame_end, digit_ok, digit, col_pos, row_pos};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= lbbf_pkg::COLUMNS_RESET;
      rows_in_use    <= lbbf_pkg::ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lbbf_pkg::REG_COLUMNS: columns_in_use <= cfg_data;
        lbbf_pkg::REG_ROWS:    rows_in_use    <= cfg_data;
        default:               ;
      endcase
    end
  end

  // raster position of the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col_pos <= '0;
        row_pos <= '0;
      end else if (row_end) begin
        col_pos <= '0;
        row_pos <= row_pos + YW'(1);
      end else begin
        col_pos <= col_pos + XW'(1);
      end
    end
  end

endmodule

/* rtl/lbbf_back.sv */
module lbbf_back #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  logic [1+1+lbbf_pkg::LABEL_W+$clog2(MAX_COLUMNS)+$clog2(MAX_ROWS)-1:0] q_data,
  output logic           q_pop,
  input  logic           o_full,
  output logic           o_push,
  output lbbf_pkg::res_t o_data
);

  localparam int XW = $clog2(MAX_COLUMNS);
  localparam int YW = $clog2(MAX_ROWS);
  localparam int NL = lbbf_pkg::NUM_LABELS;
  localparam int LW = lbbf_pkg::LABEL_W;
  localparam int CW = lbbf_pkg::COORD_W;

  typedef struct packed {
    logic          frame_end;
    logic          digit_ok;
    logic [LW-1:0] digit;
    logic [XW-1:0] col;
    logic [YW-1:0] row;
  } entry_t;

  entry_t head;

  // per-label box lanes of the frame in progress
  logic [NL-1:0]  seen;
  logic [NL-1:0]  seen_next;
  logic [XW-1:0]  min_col [NL];
  logic [XW-1:0]  max_col [NL];
  logic [YW-1:0]  min_row [NL];
  logic [YW-1:0]  max_row [NL];
  logic [XW-1:0]  min_col_next [NL];
  logic [XW-1:0]  max_col_next [NL];
  logic [YW-1:0]  min_row_next [NL];
  logic [YW-1:0]  max_row_next [NL];
  logic [LW-1:0]  order [NL];
  logic [LW-1:0]  order_next [NL];
  logic [lbbf_pkg::COUNT_W-1:0] count;
  logic [lbbf_pkg::COUNT_W-1:0] count_next;
  logic [NL-1:0]  qual;
  logic [NL-1:0]  qpos;
  logic           take;
  logic           hit;
  logic           first;

  // finished frame waiting to be emitted
  logic           busy;
  logic [NL-1:0]  mask;
  logic [CW-1:0]  bank_lcol [NL];
  logic [CW-1:0]  bank_rcol [NL];
  logic [CW-1:0]  bank_trow [NL];
  logic [CW-1:0]  bank_brow [NL];
  logic [LW-1:0]  bank_order [NL];
  logic [NL-1:0]  pick;
  logic [LW-1:0]  pick_pos;
  logic [LW-1:0]  lbl;
  logic [NL-1:0]  rest;

  assign head  = entry_t'(q_data);
  // a frame end waits until the previous frame has been emitted
  assign q_pop = !q_empty && (!head.frame_end || !busy);
  assign take  = q_pop;
  assign first = take && head.digit_ok && !seen[head.digit];

  // lane updates: compare and store for the matching label
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      hit             = take && head.digit_ok && (head.digit == LW'(i));
      seen_next[i]    = seen[i] || hit;
      min_col_next[i] = min_col[i];
      max_col_next[i] = max_col[i];
      min_row_next[i] = min_row[i];
      max_row_next[i] = max_row[i];
      if (hit && !seen[i]) begin
        min_col_next[i] = head.col;
        max_col_next[i] = head.col;
        min_row_next[i] = head.row;
        max_row_next[i] = head.row;
      end else if (hit) begin
        if (head.col < min_col[i]) min_col_next[i] = head.col;
        if (head.col > max_col[i]) max_col_next[i] = head.col;
        if (head.row < min_row[i]) min_row_next[i] = head.row;
        if (head.row > max_row[i]) max_row_next[i] = head.row;
      end
      qual[i] = (min_col_next[i] != max_col_next[i]) && (min_row_next[i] != max_row_next[i]);
    end
  end

  // appearance order
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      order_next[i] = order[i];
    end
    count_next = count;
    if (first) begin
      order_next[count] = head.digit;
      count_next        = count + lbbf_pkg::COUNT_W'(1);
    end
  end

  // qualifying boxes by position in the appearance order
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      qpos[k] = (lbbf_pkg::COUNT_W'(k) < count_next) && qual[order_next[k]];
    end
  end

  // lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= '0;
      count <= '0;
    end else if (take && head.frame_end) begin
      seen  <= '0;
      count <= '0;
    end else begin
      seen  <= seen_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      min_col[i] <= min_col_next[i];
      max_col[i] <= max_col_next[i];
      min_row[i] <= min_row_next[i];
      max_row[i] <= max_row_next[i];
      order[i]   <= order_next[i];
    end
  end

  // lowest pending position
  always_comb begin
    pick     = '0;
    pick_pos = '0;
    for (int k = NL - 1; k >= 0; k--) begin
      if (mask[k]) begin
        pick     = '0;
        pick[k]  = 1'b1;
        pick_pos = LW'(k);
      end
    end
    rest = mask & ~pick;
    lbl  = bank_order[pick_pos];
  end

  // result formation
  always_comb begin
    o_push = busy && !o_full;
    o_data = '0;
    if (mask != '0) begin
      o_data.box_valid    = 1'b1;
      o_data.label_digit  = lbl;
      o_data.left_column  = bank_lcol[lbl];
      o_data.top_row      = bank_trow[lbl];
      o_data.right_column = bank_rcol[lbl];
      o_data.bottom_row   = bank_brow[lbl];
      o_data.last_box     = (rest == '0);
    end else begin
      o_data.last_box = 1'b1;
    end
  end

  // emitter control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mask <= '0;
    end else if (take && head.frame_end) begin
      busy <= 1'b1;
      mask <= qpos;
    end else if (o_push) begin
      mask <= rest;
      if (rest == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // snapshot of the finished frame
  always_ff @(posedge clk) begin
    if (take && head.frame_end) begin
      for (int i = 0; i < NL; i++) begin
        bank_lcol[i]  <= CW'(min_col_next[i]);
        bank_rcol[i]  <= CW'(max_col_next[i]);
        bank_trow[i]  <= CW'(min_row_next[i]);
        bank_brow[i]  <= CW'(max_row_next[i]);
        bank_order[i] <= order_next[i];
      end
    end
  end

endmodule

/* rtl/label_bounding_box_finder_top.sv */
// Per-label bounding box finder.
// Cells of a frame arrive in raster order on the input queue port (push/full,
// cell_code). For each digit label '0'..'9' the block tracks the smallest and
// largest column and row. After the frame's last cell it delivers one result
// per label whose box has nonzero width and height, in order of first
// appearance, with last_box set on the final one; a frame with no such box
// gives a single result with box_valid low and last_box high.
// Results leave on the output queue port (empty/pop); a transfer happens when
// pop is high while empty is low.
// Throughput: one cell per cycle while full is low. Results are emitted one per
// cycle while the result queue has room, up to ten per frame, by the back end,
// from a snapshot taken when the frame's last cell leaves the cell queue.
// A frame end waits in the four-entry cell queue while the previous frame's
// results are still being emitted; cells keep flowing until that queue fills.
// When the receiver stalls, the four-entry result queue fills, the back end
// stops emitting, and full rises once the cell queue is full as well.
// Frame size comes from cfg_write/cfg_index/cfg_data (columns, rows), clamped
// to 1..MAX. Reset clears position, label state and both queues and restores
// 140 columns by 50 rows.
module label_bounding_box_finder_top #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [lbbf_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            push,
  input  logic [lbbf_pkg::CODE_W-1:0]     cell_code,
  output logic                            full,
  output logic                            empty,
  input  logic                            pop,
  output logic                            box_valid,
  output logic [lbbf_pkg::LABEL_W-1:0]    label_digit,
  output logic [lbbf_pkg::COORD_W-1:0]    left_column,
  output logic [lbbf_pkg::COORD_W-1:0]    top_row,
  output logic [lbbf_pkg::COORD_W-1:0]    right_column,
  output logic [lbbf_pkg::COORD_W-1:0]    bottom_row,
  output logic                            last_box
);

  localparam int ENT_W = 2 + lbbf_pkg::LABEL_W + $clog2(MAX_COLUMNS) + $clog2(MAX_ROWS);
  localparam int RES_W = $bits(lbbf_pkg::res_t);

  logic             q_push;
  logic [ENT_W-1:0] q_wdata;
  logic             q_full;
  logic             q_pop;
  logic [ENT_W-1:0] q_rdata;
  logic             q_empty;
  logic             o_push;
  logic             o_full;
  lbbf_pkg::res_t   o_wdata;
  lbbf_pkg::res_t   o_rdata;
  logic [RES_W-1:0] o_rbits;

  lbbf_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .cell_code (cell_code),
    .full      (full),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  // cell queue between front and back
  lbbf_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (lbbf_pkg::QUEUE_DEPTH)
  ) u_cell_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  lbbf_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_data  (o_wdata)
  );

  // result queue toward the receiver
  lbbf_fifo #(
    .WIDTH (RES_W),
    .DEPTH (lbbf_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (o_push),
    .wr_data (o_wdata),
    .full    (o_full),
    .rd_en   (pop),
    .rd_data (o_rbits),
    .empty   (empty)
  );

  assign o_rdata      = lbbf_pkg::res_t'(o_rbits);
  assign box_valid    = o_rdata.box_valid;
  assign label_digit  = o_rdata.label_digit;
  assign left_column  = o_rdata.left_column;
  assign top_row      = o_rdata.top_row;
  assign right_column = o_rdata.right_column;
  assign bottom_row   = o_rdata.bottom_row;
  assign last_box     = o_rdata.last_box;

endmodule

/* rtl/lbbf_checker.sv */
module lbbf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         empty,
  input logic                         pop,
  input logic                         box_valid,
  input logic [lbbf_pkg::LABEL_W-1:0] label_digit,
  input logic [lbbf_pkg::COORD_W-1:0] left_column,
  input logic [lbbf_pkg::COORD_W-1:0] top_row,
  input logic [lbbf_pkg::COORD_W-1:0] right_column,
  input logic [lbbf_pkg::COORD_W-1:0] bottom_row,
  input logic                         last_box
);

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // an empty-frame result always closes its frame
  a_empty_frame_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !box_valid) |-> last_box)
    else $error("empty-frame result without last_box");

  // an empty-frame result carries all-zero fields
  a_empty_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !box_valid) |-> (label_digit == '0 && left_column == '0 && top_row == '0
                                && right_column == '0 && bottom_row == '0))
    else $error("empty-frame result with nonzero fields");

  // a box names a digit label
  a_label_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && box_valid) |-> (label_digit <= lbbf_pkg::LABEL_W'(lbbf_pkg::NUM_LABELS - 1)))
    else $error("label out of range");

  // a waiting result's box_valid, label, left column and last_box hold until its transfer
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(box_valid) && $stable(label_digit)
                          && $stable(left_column) && $stable(last_box)))
    else $error("waiting result changed");

endmodule

bind label_bounding_box_finder_top lbbf_checker u_lbbf_checker (.*);
